// ===== hdl/krl_pkg.sv =====
// ----------------------------------------------------------------------------
// krl_pkg
// Shared widths, request codes and defaults for the keyed ring list engine.
// ----------------------------------------------------------------------------
package krl_pkg;

  // Default number of slots in the list store.
  localparam int CAPACITY_DEF = 128;

  // Field widths of the request and response items.
  localparam int REQ_W = 2;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int LEN_W = 8;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

endpackage

// ===== hdl/krl_req_if.sv =====
// ----------------------------------------------------------------------------
// krl_req_if
// Request channel: valid/ready handshake carrying one list request item.
// ----------------------------------------------------------------------------
interface krl_req_if;
  import krl_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic signed [KEY_W-1:0] entry_key;
  logic [VAL_W-1:0]        entry_value;

  modport source (output valid, req_type, entry_key, entry_value, input ready);
  modport sink   (input valid, req_type, entry_key, entry_value, output ready);

endinterface

// ===== hdl/krl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// krl_rsp_if
// Response channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface krl_rsp_if;
  import krl_pkg::*;

  logic             valid;
  logic             ready;
  logic             success;
  logic [VAL_W-1:0] found_value;
  logic [LEN_W-1:0] list_length;
  logic             is_empty;
  logic             is_full;

  modport source (output valid, success, found_value, list_length, is_empty, is_full,
                  input ready);
  modport sink   (input valid, success, found_value, list_length, is_empty, is_full,
                  output ready);

endinterface

// ===== hdl/keyed_ring_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// keyed_ring_list_engine_top
// Ordered list of keyed entries held in one RAM. Append writes at the tail,
// delete compacts the survivors in place, search returns the first match.
//
//   channel  dir  handshake    payload
//   req      in   valid/ready  req_type, entry_key, entry_value
//   rsp      out  valid/ready  success, found_value, list_length, is_empty, is_full
//
// Append and unknown requests go from accept straight to the finish state, then
// into the result register. Delete scans the whole list; search stops early on
// a match. The single read port of the entry RAM sets the scan pace.
// Reset is synchronous and clears only control state; the RAM needs no clear.
// A result waiting in the output register does not block the scan; a new
// request is taken once the previous result has moved into that register.
// ----------------------------------------------------------------------------
module keyed_ring_list_engine_top #(
  parameter int CAPACITY = krl_pkg::CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  krl_req_if.sink    req,
  krl_rsp_if.source  rsp
);
  import krl_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int RAM_W  = KEY_W + VAL_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]       state;
  logic [REQ_W-1:0] req_type_q;
  logic [KEY_W-1:0] key_q;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rd_idx;
  logic [CNT_W-1:0] kept;
  logic             pend;
  logic             hit;
  logic [VAL_W-1:0] found;

  logic             accept;
  logic             append_ok;
  logic             issue;
  logic             match;
  logic             keep_wr;
  logic             scan_done;
  logic             out_free;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [RAM_W-1:0]  ram_wdata;
  logic [RAM_W-1:0]  ram_rdata;
  logic [KEY_W-1:0]  rd_key;
  logic [VAL_W-1:0]  rd_val;

  logic             out_valid;
  logic             out_success;
  logic [VAL_W-1:0] out_found;
  logic [LEN_W-1:0] out_length;
  logic             out_empty;
  logic             out_full;

  // Handshake and request decode.
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign append_ok = accept && (req.req_type == REQ_APPEND) && (count != CAP_CNT);
  assign out_free  = !out_valid || rsp.ready;

  // Scan control: one read issued per cycle, its data checked in the next cycle.
  assign rd_key    = ram_rdata[RAM_W-1 -: KEY_W];
  assign rd_val    = ram_rdata[VAL_W-1:0];
  assign issue     = (state == S_SCAN) && (rd_idx < count)
                     && !((req_type_q == REQ_SEARCH) && hit);
  assign match     = pend && (rd_key == key_q);
  assign keep_wr   = (state == S_SCAN) && pend && (req_type_q == REQ_DELETE) && !match;
  assign scan_done = (state == S_SCAN) && !issue && !pend;

  // Write port: tail append from idle, or compaction copy during a delete.
  assign ram_we    = append_ok || keep_wr;
  assign ram_waddr = keep_wr ? kept[ADDR_W-1:0] : count[ADDR_W-1:0];
  assign ram_wdata = keep_wr ? ram_rdata : {req.entry_key, req.entry_value};

  krl_ram #(
    .WIDTH (RAM_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      pend <= issue;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_type_q <= req.req_type;
            key_q      <= req.entry_key;
            found      <= '0;
            rd_idx     <= '0;
            kept       <= '0;
            if (append_ok) begin
              count <= count + CNT_W'(1);
            end
            if (((req.req_type == REQ_DELETE) || (req.req_type == REQ_SEARCH))
                && (count != '0)) begin
              hit   <= 1'b0;
              state <= S_SCAN;
            end else begin
              hit   <= append_ok;
              state <= S_FINISH;
            end
          end
        end
        S_SCAN: begin
          if (issue) begin
            rd_idx <= rd_idx + CNT_W'(1);
          end
          if (keep_wr) begin
            kept <= kept + CNT_W'(1);
          end
          if (match && !hit) begin
            hit <= 1'b1;
            if (req_type_q == REQ_SEARCH) begin
              found <= rd_val;
            end
          end
          if (scan_done) begin
            if (req_type_q == REQ_DELETE) begin
              count <= kept;
            end
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FINISH) && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && out_free) begin
      out_success <= hit;
      out_found   <= found;
      out_length  <= LEN_W'(count);
      out_empty   <= (count == '0);
      out_full    <= (count == CAP_CNT);
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.success     = out_success;
  assign rsp.found_value = out_found;
  assign rsp.list_length = out_length;
  assign rsp.is_empty    = out_empty;
  assign rsp.is_full     = out_full;

`ifndef SYNTH
  // The entry count never exceeds the store size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("entry count above capacity");

  // Compaction writes always land below the slot being read.
  a_compact_behind: assert property (@(posedge clk) disable iff (rst)
    keep_wr |-> (kept < rd_idx))
    else $error("compaction write overtook the read pointer");

  // An accepted append into a non-full list grows it by one.
  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    append_ok |=> (count == $past(count) + CNT_W'(1)))
    else $error("append did not grow the list");

  // A scan only runs over a non-empty list.
  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (count != '0))
    else $error("scan started on an empty list");

  // A failed request never reports a found value.
  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.success) |-> (rsp.found_value == '0))
    else $error("found value set on an unsuccessful result");
`endif

endmodule

// ===== hdl/krl_ram.sv =====
// ----------------------------------------------------------------------------
// krl_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module krl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for keyed_ring_list_engine_top. A shadow copy of the list
// predicts every response. Requests are sent through the request channel with
// random gaps and the response channel stalls at random. Directed tests cover
// the empty list, each request type with extreme keys and values, and a list
// filled to capacity. Random traffic then swings the list between empty and
// full.
// ----------------------------------------------------------------------------
module tb;
  import krl_pkg::*;

  localparam int CAPACITY      = CAPACITY_DEF;
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 200;
  localparam int PHASE_ITEMS   = 209;
  localparam int MAX_REPORTED  = 10;

  // The request field allows a fourth code that the block must ignore.
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  typedef enum {MIX_GROW, MIX_BALANCED, MIX_SHRINK} traffic_mix_t;

  typedef struct packed {
    logic             success;
    logic [VAL_W-1:0] found_value;
    logic [LEN_W-1:0] list_length;
    logic             is_empty;
    logic             is_full;
  } list_status_t;

  logic clk;
  logic rst;

  krl_req_if req_ch ();
  krl_rsp_if rsp_ch ();

  keyed_ring_list_engine_top #(.CAPACITY(CAPACITY)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the list, kept in order from the head.
  logic [KEY_W-1:0] shadow_keys [CAPACITY];
  logic [VAL_W-1:0] shadow_vals [CAPACITY];
  int               shadow_count = 0;

  list_status_t pending_responses[$];

  logic             idle_on = 1'b1;
  logic [KEY_W-1:0] key_pool [16];
  int               error_count = 0;
  int               responses_checked = 0;
  int               idle_cycles = 0;
  int               op_counts [4] = '{0, 0, 0, 0};
  int               full_requests = 0;
  int               empty_transitions = 0;
  int               longest_list = 0;

  // Clock generation.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Applies one request to the shadow list and returns the response it causes.
  function automatic list_status_t predict_response(input logic [REQ_W-1:0] op,
                                                    input logic [KEY_W-1:0] key,
                                                    input logic [VAL_W-1:0] val);
    list_status_t r;
    int           kept;
    r = '0;
    kept = 0;
    case (op)
      REQ_APPEND: begin
        if (shadow_count < CAPACITY) begin
          shadow_keys[shadow_count] = key;
          shadow_vals[shadow_count] = val;
          shadow_count++;
          r.success = 1'b1;
        end
      end
      REQ_DELETE: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_keys[i] != key) begin
            shadow_keys[kept] = shadow_keys[i];
            shadow_vals[kept] = shadow_vals[i];
            kept++;
          end else begin
            r.success = 1'b1;
          end
        end
        shadow_count = kept;
      end
      REQ_SEARCH: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (!r.success && shadow_keys[i] == key) begin
            r.success     = 1'b1;
            r.found_value = shadow_vals[i];
          end
        end
      end
      default: begin
      end
    endcase
    r.list_length = LEN_W'(shadow_count);
    r.is_empty    = (shadow_count == 0);
    r.is_full     = (shadow_count == CAPACITY);
    return r;
  endfunction

  // Sender gap: usually none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Keys mostly come from a small pool so that deletes and searches hit.
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, 15)];
    return $urandom;
  endfunction

  function automatic logic [KEY_W-1:0] pick_stored_key(input int hit_percent);
    if (shadow_count > 0 && $urandom_range(0, 99) < hit_percent)
      return shadow_keys[$urandom_range(0, shadow_count - 1)];
    return pick_key();
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Sends one request item and records the response it must cause.
  task automatic send_request(input logic [REQ_W-1:0] op,
                              input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] val);
    int           gap;
    int           before_count;
    list_status_t want;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= op;
    req_ch.entry_key   <= key;
    req_ch.entry_value <= val;
    do @(posedge clk); while (!req_ch.ready);
    before_count = shadow_count;
    want = predict_response(op, key, val);
    pending_responses.push_back(want);
    op_counts[op]++;
    if (want.is_full) full_requests++;
    if (before_count > 0 && shadow_count == 0) empty_transitions++;
    if (shadow_count > longest_list) longest_list = shadow_count;
    @(negedge clk);
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    error_count++;
    if (error_count <= MAX_REPORTED)
      $display("ERROR response %0d: %s expected 0x%08h, got 0x%08h",
               responses_checked, what, want, got);
  endtask

  // Requests on an empty list, including the ignored request code.
  task automatic test_empty_list();
    send_request(REQ_SEARCH, '0, '0);
    send_request(REQ_DELETE, KEY_MIN, '1);
    send_request(REQ_UNKNOWN, KEY_MAX, '1);
    send_request(REQ_SEARCH, KEY_MIN, 32'h0000_0001);
  endtask

  // Each request type with extreme keys and values, duplicates and misses.
  task automatic test_basic_requests();
    send_request(REQ_APPEND, KEY_MIN, '0);
    send_request(REQ_APPEND, KEY_MAX, '1);
    send_request(REQ_APPEND, 32'sd5, 32'h1234_5678);
    send_request(REQ_APPEND, 32'sd5, 32'hA5A5_A5A5);
    send_request(REQ_APPEND, -32'sd1, 32'h5A5A_5A5A);
    send_request(REQ_SEARCH, 32'sd5, '0);
    send_request(REQ_SEARCH, KEY_MAX, '0);
    send_request(REQ_SEARCH, KEY_MIN, '1);
    send_request(REQ_SEARCH, 32'sd7, '0);
    send_request(REQ_UNKNOWN, 32'sd5, 32'hDEAD_BEEF);
    send_request(REQ_DELETE, 32'sd5, '0);
    send_request(REQ_SEARCH, 32'sd5, '0);
    send_request(REQ_DELETE, 32'sd7, '0);
    send_request(REQ_DELETE, KEY_MIN, '0);
    send_request(REQ_DELETE, -32'sd1, '0);
    send_request(REQ_DELETE, KEY_MAX, '0);
  endtask

  // Fills the list, exercises the full list, then empties it by deletes.
  task automatic test_full_list();
    logic [KEY_W-1:0] drain_keys [8];
    idle_on = 1'b0;
    for (int i = 0; i < CAPACITY; i++)
      send_request(REQ_APPEND, KEY_W'(i % 8), pick_value());
    idle_on = 1'b1;
    send_request(REQ_APPEND, 32'sd99, '1);
    send_request(REQ_SEARCH, 32'sd7, '0);
    send_request(REQ_SEARCH, 32'sd99, '0);
    send_request(REQ_UNKNOWN, 32'sd0, '1);
    send_request(REQ_DELETE, 32'sd3, '0);
    for (int i = 0; i < CAPACITY / 8; i++)
      send_request(REQ_APPEND, -32'sd5, pick_value());
    send_request(REQ_APPEND, 32'sd0, '0);
    drain_keys = '{32'sd0, 32'sd1, 32'sd2, 32'sd4, 32'sd5, 32'sd6, 32'sd7, -32'sd5};
    foreach (drain_keys[i])
      send_request(REQ_DELETE, drain_keys[i], '0);
  endtask

  // Random traffic in phases that push the list toward full and toward empty.
  task automatic test_random_traffic();
    traffic_mix_t     plan [8];
    int               w_app;
    int               w_del;
    int               r;
    logic [KEY_W-1:0] key;
    plan = '{MIX_GROW, MIX_BALANCED, MIX_GROW, MIX_SHRINK,
             MIX_BALANCED, MIX_GROW, MIX_SHRINK, MIX_BALANCED};
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = KEY_MIN;
    key_pool[3] = KEY_MAX;
    key_pool[4] = 32'd1;
    for (int i = 5; i < 16; i++) key_pool[i] = $urandom;
    foreach (plan[p]) begin
      idle_on = (p != 4);
      case (plan[p])
        MIX_GROW:     begin w_app = 65; w_del = 10; end
        MIX_BALANCED: begin w_app = 45; w_del = 20; end
        default:      begin w_app = 25; w_del = 40; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < w_app) begin
          send_request(REQ_APPEND, pick_key(), pick_value());
        end else if (r < w_app + w_del) begin
          key = pick_stored_key(50);
          send_request(REQ_DELETE, key, pick_value());
        end else if (r < 95) begin
          key = pick_stored_key(70);
          send_request(REQ_SEARCH, key, pick_value());
        end else begin
          send_request(REQ_UNKNOWN, $urandom, $urandom);
        end
      end
    end
    idle_on = 1'b1;
  endtask

  // Response ready: random stalls, mostly short, none while idling is off.
  always @(negedge clk) begin : drive_rsp_ready
    int stall_left;
    int r;
    if (!idle_on) begin
      stall_left = 0;
      rsp_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b0;
        stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
    end
  end

  // Compares each accepted response with the oldest expected one.
  always @(posedge clk) begin : check_responses
    list_status_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_responses.size() == 0) begin
        note_mismatch("response with none pending, list_length", '0,
                      32'(rsp_ch.list_length));
      end else begin
        want = pending_responses.pop_front();
        if (rsp_ch.success !== want.success)
          note_mismatch("success", 32'(want.success), 32'(rsp_ch.success));
        if (rsp_ch.found_value !== want.found_value)
          note_mismatch("found_value", want.found_value, rsp_ch.found_value);
        if (rsp_ch.list_length !== want.list_length)
          note_mismatch("list_length", 32'(want.list_length), 32'(rsp_ch.list_length));
        if (rsp_ch.is_empty !== want.is_empty)
          note_mismatch("is_empty", 32'(want.is_empty), 32'(rsp_ch.is_empty));
        if (rsp_ch.is_full !== want.is_full)
          note_mismatch("is_full", 32'(want.is_full), 32'(rsp_ch.is_full));
      end
      responses_checked++;
    end
  end

  // Watchdog: ends the run when neither channel moves an item for too long.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired with %0d responses outstanding",
               pending_responses.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_APPEND;
    req_ch.entry_key   = '0;
    req_ch.entry_value = '0;
    rsp_ch.ready       = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_list();
    test_basic_requests();
    test_full_list();
    test_random_traffic();
    req_ch.valid <= 1'b0;

    wait (pending_responses.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d appends, %0d deletes, %0d searches, %0d unknown; %0d checked.",
             op_counts[REQ_APPEND], op_counts[REQ_DELETE], op_counts[REQ_SEARCH],
             op_counts[REQ_UNKNOWN], responses_checked);
    $display("Longest list %0d entries, %0d requests left it full, emptied %0d times.",
             longest_list, full_requests, empty_transitions);
    if (error_count == 0 && pending_responses.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches found", error_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
